// ===== rtl/mbma_pkg.sv =====
// package for the multichannel burst moving average
// fixed field widths, output queue sizing and the result record type
// no dependencies
`default_nettype none

package mbma_pkg;

  localparam int CH_BITS      = 2;
  localparam int SAMPLE_BITS  = 12;
  localparam int OUT_BITS     = 16;
  localparam int FILTER_SHIFT = 4;
  localparam int OQ_DEPTH     = 8;
  localparam int OQ_AW        = 3;
  localparam int OQ_CW        = 4;

  typedef logic [CH_BITS-1:0]     chan_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    chan_t               out_channel;
    logic [OUT_BITS-1:0] filtered;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/multichannel_burst_moving_average.sv =====
// multichannel burst moving average, top level
// depends on mbma_pkg, mbma_burst, mbma_window, mbma_outq
//
// input channel: in_valid / in_stall carry channel and sample; one sample
// per cycle is taken unless stalled. samples of channels >= CHANNELS are dropped.
// every BURST samples of a channel close a burst; its sum replaces the
// entry at the shared window slot and the channel's total over WINDOW
// bursts is reported on out_valid / out_stall as out_channel and filtered
// (total shifted right by four). the slot moves after the last channel's
// burst.
// a closing sample passes the burst read stage, the burst register and the
// window stage before its result is queued. throughput: one sample per cycle
// unless stalled, kept by forwarding in the burst and window memory writes.
// results wait in an eight-entry queue; in_stall rises only when the
// queue plus samples still in flight could fill it, so a stalling receiver
// stops the input only after results pile up.
// reset clears burst state, totals and the slot at once; the window
// history reads as zero until written, with no clearing pass.
`default_nettype none

module multichannel_burst_moving_average #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 16,
  parameter int BURST    = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mbma_pkg::chan_t     channel,
  input  mbma_pkg::sample_t   sample,
  output logic                out_valid,
  input  logic                out_stall,
  output mbma_pkg::chan_t     out_channel,
  output logic [mbma_pkg::OUT_BITS-1:0] filtered
);
  import mbma_pkg::*;

  localparam int ACC_W = SAMPLE_BITS + $clog2(BURST);
  localparam int IDX_W = $clog2(CHANNELS * WINDOW);
  localparam int OCC_W = OQ_CW + 1;

  logic             in_range;
  logic             take;
  logic             burst_pend;
  logic             bst_valid;
  chan_t            bst_ch;
  logic [ACC_W-1:0] bst_sum;
  logic [IDX_W-1:0] bst_idx;
  logic             win_pend;
  logic             res_valid;
  result_t          res;
  result_t          head;
  logic [OQ_CW-1:0] q_count;
  logic [OCC_W-1:0] occupancy;

  assign in_range  = ({3'b000, channel} < 5'(CHANNELS));
  assign occupancy = OCC_W'(q_count) + OCC_W'(burst_pend) + OCC_W'(bst_valid)
                     + OCC_W'(win_pend);
  assign in_stall  = (occupancy >= OCC_W'(OQ_DEPTH));
  assign take      = in_valid && !in_stall && in_range;

  mbma_burst #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW),
    .BURST    (BURST),
    .ACC_W    (ACC_W),
    .IDX_W    (IDX_W)
  ) u_burst (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .take_ch     (channel),
    .take_sample (sample),
    .pend        (burst_pend),
    .bst_valid   (bst_valid),
    .bst_ch      (bst_ch),
    .bst_sum     (bst_sum),
    .bst_idx     (bst_idx)
  );

  mbma_window #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW),
    .ACC_W    (ACC_W),
    .IDX_W    (IDX_W)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .bst_valid (bst_valid),
    .bst_ch    (bst_ch),
    .bst_sum   (bst_sum),
    .bst_idx   (bst_idx),
    .pend      (win_pend),
    .res_valid (res_valid),
    .res       (res)
  );

  mbma_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid),
    .din   (res),
    .pop   (out_valid && !out_stall),
    .valid (out_valid),
    .dout  (head),
    .count (q_count)
  );

  assign out_channel = head.out_channel;
  assign filtered    = head.filtered;

endmodule

`default_nettype wire

// ===== rtl/mbma_burst.sv =====
// per-channel burst accumulator held in a memory with a registered read;
// read-modify-write with forwarding, owns the shared window slot
// depends on mbma_pkg
`default_nettype none

module mbma_burst #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 16,
  parameter int BURST    = 16,
  parameter int ACC_W    = 16,
  parameter int IDX_W    = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  mbma_pkg::chan_t     take_ch,
  input  mbma_pkg::sample_t   take_sample,
  output logic                pend,
  output logic                bst_valid,
  output mbma_pkg::chan_t     bst_ch,
  output logic [ACC_W-1:0]    bst_sum,
  output logic [IDX_W-1:0]    bst_idx
);
  import mbma_pkg::*;

  localparam int CI_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = (BURST > 1) ? $clog2(BURST) : 1;
  localparam int SLOT_W = $clog2(WINDOW);
  localparam int ENT_W  = CNT_W + ACC_W;

  logic [ENT_W-1:0] bmem [0:CHANNELS-1];
  logic [CHANNELS-1:0] bvalid;

  logic             s1_valid;
  chan_t            s1_ch;
  sample_t          s1_sample;
  logic [ENT_W-1:0] s1_rdata;
  logic             s1_bval;
  logic             s1_fwd;
  logic [ENT_W-1:0] s1_fdata;
  logic [SLOT_W-1:0] slot;

  logic [ENT_W-1:0] old_ent;
  logic [CNT_W-1:0] old_cnt;
  logic [ACC_W-1:0] old_acc;
  logic [ACC_W-1:0] sum;
  logic             done;
  logic [ENT_W-1:0] wr_data;
  logic [CI_W-1:0]  take_ci;
  logic [CI_W-1:0]  s1_ci;

  assign take_ci = take_ch[CI_W-1:0];
  assign s1_ci   = s1_ch[CI_W-1:0];

  always_comb begin
    if (s1_fwd) begin
      old_ent = s1_fdata;
    end else if (s1_bval) begin
      old_ent = s1_rdata;
    end else begin
      old_ent = '0;
    end
    old_cnt = old_ent[ENT_W-1:ACC_W];
    old_acc = old_ent[ACC_W-1:0];
    sum     = old_acc + ACC_W'(s1_sample);
    done    = (old_cnt == CNT_W'(BURST - 1));
    wr_data = done ? '0 : {old_cnt + CNT_W'(1), sum};
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_rdata <= bmem[take_ci];
    end
    if (s1_valid) begin
      bmem[s1_ci] <= wr_data;
    end
    s1_ch     <= take_ch;
    s1_sample <= take_sample;
    s1_bval   <= bvalid[take_ci];
    s1_fwd    <= s1_valid && (s1_ci == take_ci);
    s1_fdata  <= wr_data;
    bst_ch    <= s1_ch;
    bst_sum   <= sum;
    bst_idx   <= IDX_W'(s1_ch) * IDX_W'(WINDOW) + IDX_W'(slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      bst_valid <= 1'b0;
      bvalid    <= '0;
      slot      <= '0;
    end else begin
      s1_valid  <= take;
      bst_valid <= s1_valid && done;
      if (s1_valid) begin
        bvalid[s1_ci] <= 1'b1;
      end
      if (s1_valid && done && (s1_ch == CH_BITS'(CHANNELS - 1))) begin
        slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + SLOT_W'(1);
      end
    end
  end

  assign pend = s1_valid;

endmodule

`default_nettype wire

// ===== rtl/mbma_window.sv =====
// window history memory and per-channel running totals
// replaces the oldest burst sum and forms the filtered result
// depends on mbma_pkg
`default_nettype none

module mbma_window #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 16,
  parameter int ACC_W    = 16,
  parameter int IDX_W    = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                bst_valid,
  input  mbma_pkg::chan_t     bst_ch,
  input  logic [ACC_W-1:0]    bst_sum,
  input  logic [IDX_W-1:0]    bst_idx,
  output logic                pend,
  output logic                res_valid,
  output mbma_pkg::result_t   res
);
  import mbma_pkg::*;

  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TOT_W = ACC_W + $clog2(WINDOW);
  localparam int EXT_W = TOT_W + OUT_BITS;

  logic [ACC_W-1:0] hmem [0:DEPTH-1];
  logic [DEPTH-1:0] hvalid;
  logic [TOT_W-1:0] total [0:CHANNELS-1];

  logic             w_valid;
  chan_t            w_ch;
  logic [ACC_W-1:0] w_sum;
  logic [IDX_W-1:0] w_idx;
  logic [ACC_W-1:0] w_rdata;
  logic             w_hval;
  logic             w_fwd;
  logic [ACC_W-1:0] w_fdata;

  logic [CI_W-1:0]  w_ci;
  logic [ACC_W-1:0] old_sum;
  logic [TOT_W-1:0] new_total;
  logic [EXT_W-1:0] ext;

  assign w_ci = w_ch[CI_W-1:0];

  always_comb begin
    if (w_fwd) begin
      old_sum = w_fdata;
    end else if (w_hval) begin
      old_sum = w_rdata;
    end else begin
      old_sum = '0;
    end
    new_total = total[w_ci] + TOT_W'(w_sum) - TOT_W'(old_sum);
    ext       = EXT_W'(new_total);
  end

  always_ff @(posedge clk) begin
    if (bst_valid) begin
      w_rdata <= hmem[bst_idx];
    end
    if (w_valid) begin
      hmem[w_idx] <= w_sum;
    end
    w_ch    <= bst_ch;
    w_sum   <= bst_sum;
    w_idx   <= bst_idx;
    w_hval  <= hvalid[bst_idx];
    w_fwd   <= w_valid && (w_idx == bst_idx);
    w_fdata <= w_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
      hvalid  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        total[i] <= '0;
      end
    end else begin
      w_valid <= bst_valid;
      if (w_valid) begin
        hvalid[w_idx] <= 1'b1;
        total[w_ci]   <= new_total;
      end
    end
  end

  assign pend            = w_valid;
  assign res_valid       = w_valid;
  assign res.out_channel = w_ch;
  assign res.filtered    = ext[FILTER_SHIFT +: OUT_BITS];

endmodule

`default_nettype wire

// ===== rtl/mbma_outq.sv =====
// output queue of filtered results toward the receiver
// depends on mbma_pkg
`default_nettype none

module mbma_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mbma_pkg::result_t     din,
  input  logic                  pop,
  output logic                  valid,
  output mbma_pkg::result_t     dout,
  output logic [mbma_pkg::OQ_CW-1:0] count
);
  import mbma_pkg::*;

  result_t          qmem [0:OQ_DEPTH-1];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + OQ_CW'(1);
        2'b01:   count <= count - OQ_CW'(1);
        default: count <= count;
      endcase
    end
  end

  assign valid = (count != '0);
  assign dout  = qmem[rd_ptr];

endmodule

`default_nettype wire

// ===== tb/sv/mbma_filter_check.sv =====
// filter checker for the multichannel burst moving average
// watches both channels, predicts each window result and compares it field by field
// depends on mbma_pkg
module mbma_filter_check #(
  parameter int CHANNELS = 4,
  parameter int WINDOW   = 16,
  parameter int BURST    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  mbma_pkg::chan_t               channel,
  input  mbma_pkg::sample_t             sample,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  mbma_pkg::chan_t               out_channel,
  input  logic [mbma_pkg::OUT_BITS-1:0] filtered,
  output int                            error_count,
  output int                            pending,
  output int                            checked,
  output int                            slot_wraps
);
  timeunit 1ns;
  timeprecision 1ps;

  import mbma_pkg::*;

  localparam int SUM_BITS   = SAMPLE_BITS + $clog2(BURST);
  localparam int TOTAL_BITS = SUM_BITS + $clog2(WINDOW);
  localparam int LEN_BITS   = $clog2(BURST + 1);
  localparam int SLOT_BITS  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [SUM_BITS-1:0]   burst_sum [CHANNELS];
  logic [LEN_BITS-1:0]   burst_len [CHANNELS];
  logic [SUM_BITS-1:0]   burst_history [CHANNELS*WINDOW];
  logic [TOTAL_BITS-1:0] run_total [CHANNELS];
  logic [SLOT_BITS-1:0]  slot;
  result_t               filter_results_q[$];
  int                    errors;
  int                    n_checked;
  int                    n_wraps;

  function automatic void add_sample(chan_t ch, sample_t s);
    int                  c;
    int                  idx;
    logic [SUM_BITS-1:0] closed;
    result_t             r;
    c = int'(ch);
    if (c >= CHANNELS) return;
    burst_sum[c] = burst_sum[c] + SUM_BITS'(s);
    burst_len[c] = burst_len[c] + 1'b1;
    if (burst_len[c] < BURST) return;
    closed = burst_sum[c];
    burst_sum[c] = '0;
    burst_len[c] = '0;
    idx = c * WINDOW + int'(slot);
    run_total[c] = run_total[c] + TOTAL_BITS'(closed) - TOTAL_BITS'(burst_history[idx]);
    burst_history[idx] = closed;
    r.out_channel = ch;
    r.filtered = OUT_BITS'(run_total[c] >> FILTER_SHIFT);
    filter_results_q.push_back(r);
    if (c == CHANNELS - 1) begin
      if (int'(slot) == WINDOW - 1) begin
        slot = '0;
        n_wraps++;
      end else begin
        slot = slot + 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        burst_sum[c] = '0;
        burst_len[c] = '0;
        run_total[c] = '0;
      end
      for (int i = 0; i < CHANNELS * WINDOW; i++) burst_history[i] = '0;
      slot = '0;
      filter_results_q.delete();
      errors = 0;
      n_checked = 0;
      n_wraps = 0;
    end else begin
      if (in_valid && !in_stall) add_sample(channel, sample);
      if (out_valid && !out_stall) begin
        if (filter_results_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, got channel %0d filtered %0d",
                   $time, out_channel, filtered);
          errors++;
        end else begin
          want = filter_results_q.pop_front();
          if (out_channel !== want.out_channel) begin
            $display("%0t: out_channel mismatch, expected %0d, got %0d",
                     $time, want.out_channel, out_channel);
            errors++;
          end
          if (filtered !== want.filtered) begin
            $display("%0t: filtered mismatch on channel %0d, expected %0d, got %0d",
                     $time, want.out_channel, want.filtered, filtered);
            errors++;
          end
          n_checked++;
        end
      end
    end
    error_count <= errors;
    pending <= filter_results_q.size();
    checked <= n_checked;
    slot_wraps <= n_wraps;
  end

endmodule

// ===== tb/sv/tb_multichannel_burst_moving_average.sv =====
// testbench top for the multichannel burst moving average
// drives samples and output stalls, gives the verdict; depends on mbma_pkg,
// mbma_filter_check and the rtl top multichannel_burst_moving_average
module tb_multichannel_burst_moving_average;
  timeunit 1ns;
  timeprecision 1ps;

  import mbma_pkg::*;

  localparam int CHANNELS   = 4;
  localparam int WINDOW     = 16;
  localparam int BURST      = 16;
  localparam int SEGMENTS   = 10;
  localparam int SEG_ITEMS  = 90;
  localparam int HOLD_OFF   = 400;
  localparam int DRAIN      = 16;
  localparam int QUIET_MAX  = 5000;

  typedef enum {PAT_ANY, PAT_FULL, PAT_ZERO, PAT_LOW} pattern_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  chan_t               channel;
  sample_t             sample;
  logic                out_valid;
  logic                out_stall;
  chan_t               out_channel;
  logic [OUT_BITS-1:0] filtered;

  int error_count;
  int pending;
  int checked;
  int slot_wraps;
  int sent;
  int quiet;
  int in_stall_cycles;
  bit hold_done;

  multichannel_burst_moving_average #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW),
    .BURST   (BURST)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .channel    (channel),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_channel(out_channel),
    .filtered   (filtered)
  );

  mbma_filter_check #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW),
    .BURST   (BURST)
  ) filter_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .channel    (channel),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_channel(out_channel),
    .filtered   (filtered),
    .error_count(error_count),
    .pending    (pending),
    .checked    (checked),
    .slot_wraps (slot_wraps)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic send_sample(chan_t c, sample_t s);
    bit may_idle;
    may_idle = !(sent >= 250 && sent < 550);
    while (may_idle && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    channel <= c;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  function automatic sample_t pick_sample(pattern_t pat);
    case (pat)
      PAT_FULL: pick_sample = '1;
      PAT_ZERO: pick_sample = '0;
      PAT_LOW:  pick_sample = sample_t'($urandom_range(15));
      default:  pick_sample = sample_t'($urandom);
    endcase
  endfunction

  initial begin
    pattern_t pat;
    chan_t    focus;
    chan_t    c;
    rst = 1'b1;
    in_valid = 1'b0;
    channel = '0;
    sample = '0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // full-scale burst on channel 0, then edge values on the others
    repeat (BURST) send_sample(chan_t'(0), '1);
    send_sample(chan_t'(1), '0);
    send_sample(chan_t'(2), '0);
    send_sample(chan_t'(3), '0);
    send_sample(chan_t'(3), '1);
    send_sample(chan_t'(1), 12'h001);
    send_sample(chan_t'(2), 12'h800);
    send_sample(chan_t'(1), 12'haaa);
    send_sample(chan_t'(2), 12'h555);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      focus = chan_t'((seg + 3) % CHANNELS);
      pat = pattern_t'($urandom_range(3));
      for (int i = 0; i < SEG_ITEMS; i++) begin
        c = ($urandom_range(99) < 80) ? focus : chan_t'($urandom_range(CHANNELS - 1));
        send_sample(c, pick_sample(($urandom_range(9) < 8) ? pat : PAT_ANY));
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("drove %0d samples, checked %0d filter results, window slot wrapped %0d times",
             sent, checked, slot_wraps);
    $display("input stalled for %0d cycles, mostly during a %0d-cycle output hold-off",
             in_stall_cycles, HOLD_OFF);
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent >= 300) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (sent >= 600 && sent < 750) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 24);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst && in_valid && in_stall) in_stall_cycles <= in_stall_cycles + 1;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, quiet);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
